[rtl/tm_pkg.sv]
// Package for the triangle metrics block: field widths, class codes and the
// sideband record carried down the pipeline. No dependencies.
package tm_pkg;

  localparam int SIDE_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int PER_W   = 18;
  localparam int DIFF_W  = SIDE_W + 1;
  localparam int SQR_W   = 2 * SIDE_W;
  localparam int XY_W    = 2 * DIFF_W;
  localparam int XYZ_W   = 3 * DIFF_W;
  localparam int ABC_W   = 3 * SIDE_W;
  localparam int AREA_W  = 24;
  localparam int RIN_W   = 16;
  localparam int ROUT_W  = 24;
  localparam int SQ_W    = 2 * AREA_W;
  localparam int RSQ_R_W = 15;
  localparam int RSQ_W   = 2 * RSQ_R_W;
  localparam int AREA_SH = 2 * FRAC_W + 4;
  localparam int XYZ_LO_W = 26;
  localparam int XYZ_HI_W = XYZ_W - XYZ_LO_W;
  localparam int PROD_W  = PER_W + XYZ_W + 1;
  localparam int ROUT_SH = FRAC_W + 2;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_RIGHT  = 2'd1,
    CLS_OBTUSE = 2'd2,
    CLS_ACUTE  = 2'd3
  } tm_class_e;

  typedef struct packed {
    tm_class_e          cls;
    logic [PER_W-1:0]   per;
    logic [ABC_W-1:0]   abc;
    logic [XYZ_W-1:0]   xyz;
    logic [AREA_W-1:0]  area;
    logic [RIN_W-1:0]   rin;
    logic               sat;
  } tm_side_t;

  localparam int SIDE_TAG_W = $bits(tm_side_t);

endpackage

[rtl/triangle_metrics.sv]
// Top level of the triangle metrics block: front arithmetic, area root,
// inradius divide and root, circumradius divide, output register.
// Depends on tm_pkg, tm_front, tm_isqrt and tm_div.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   in       | valid_i / stall_o       | side_a_i, side_b_i, side_c_i
//   out      | valid_o / stall_i       | tri_class_o, perimeter_o, area_o,
//            |                         | inner_radius_o, outer_radius_o,
//            |                         | outer_saturated_o
//
// One transfer per cycle in each direction while the output is not stalled.
// The pipeline is the bit-per-stage chain: 5 front stages, 25 area root,
// 31 inradius divide, 16 inradius root, 25 circumradius divide and the output register.
// Reset clears all valid bits. A stalled result freezes the whole pipeline;
// nothing is dropped or repeated.
module triangle_metrics import tm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [SIDE_W-1:0] side_a_i,
  input  logic [SIDE_W-1:0] side_b_i,
  input  logic [SIDE_W-1:0] side_c_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [1:0]        tri_class_o,
  output logic [PER_W-1:0]  perimeter_o,
  output logic [AREA_W-1:0] area_o,
  output logic [RIN_W-1:0]  inner_radius_o,
  output logic [ROUT_W-1:0] outer_radius_o,
  output logic              outer_saturated_o
);

  logic out_vld_q;
  logic en;
  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  logic            f_vld;
  logic [SQ_W-1:0] f_sq;
  tm_side_t        f_side;

  tm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_i),
    .side_a_i (side_a_i),
    .side_b_i (side_b_i),
    .side_c_i (side_c_i),
    .valid_o  (f_vld),
    .sq_o     (f_sq),
    .side_o   (f_side)
  );

  logic                  ar_vld;
  logic [AREA_W-1:0]     ar_root;
  logic [SIDE_TAG_W-1:0] ar_tag;
  tm_side_t              ar_side;

  tm_isqrt #(.R_W(AREA_W), .TAG_W(SIDE_TAG_W)) u_area_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .v_i     (f_sq),
    .tag_i   (f_side),
    .valid_o (ar_vld),
    .root_o  (ar_root),
    .tag_o   (ar_tag)
  );

  always_comb begin
    ar_side      = tm_side_t'(ar_tag);
    ar_side.area = ar_root;
  end

  logic                  di_vld;
  logic [RSQ_W-1:0]      di_quo;
  logic [SIDE_TAG_W-1:0] di_tag;

  tm_div #(.NUM_W(XYZ_W), .DEN_W(PER_W + 2), .Q_W(RSQ_W), .TAG_W(SIDE_TAG_W)) u_in_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ar_vld),
    .num_i   (ar_side.xyz),
    .den_i   ({ar_side.per, 2'b00}),
    .tag_i   (ar_side),
    .valid_o (di_vld),
    .quo_o   (di_quo),
    .tag_o   (di_tag)
  );

  logic                  ri_vld;
  logic [RSQ_R_W-1:0]    ri_root;
  logic [SIDE_TAG_W-1:0] ri_tag;
  tm_side_t              ri_side;

  tm_isqrt #(.R_W(RSQ_R_W), .TAG_W(SIDE_TAG_W)) u_in_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (di_vld),
    .v_i     (di_quo),
    .tag_i   (di_tag),
    .valid_o (ri_vld),
    .root_o  (ri_root),
    .tag_o   (ri_tag)
  );

  always_comb begin
    ri_side     = tm_side_t'(ri_tag);
    ri_side.rin = RIN_W'(ri_root);
    // quotient overflows 24 bits when abc >> (frac + 2 + 24) reaches the area
    ri_side.sat = AREA_W'(ri_side.abc >> (ROUT_SH + ROUT_W)) >= ri_side.area;
  end

  logic                  do_vld;
  logic [ROUT_W-1:0]     do_quo;
  logic [SIDE_TAG_W-1:0] do_tag;
  tm_side_t              do_side;

  tm_div #(.NUM_W(ABC_W - ROUT_SH), .DEN_W(AREA_W), .Q_W(ROUT_W),
           .TAG_W(SIDE_TAG_W)) u_out_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ri_vld),
    .num_i   (ri_side.abc[ABC_W-1:ROUT_SH]),
    .den_i   (ri_side.area),
    .tag_i   (ri_side),
    .valid_o (do_vld),
    .quo_o   (do_quo),
    .tag_o   (do_tag)
  );

  assign do_side = tm_side_t'(do_tag);

  logic              tri_ok;
  logic [1:0]        cls_q;
  logic [PER_W-1:0]  per_q;
  logic [AREA_W-1:0] area_q;
  logic [RIN_W-1:0]  rin_q;
  logic [ROUT_W-1:0] rout_q;
  logic              sat_q;
  assign tri_ok = do_side.cls != CLS_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= do_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q  <= do_side.cls;
      per_q  <= do_side.per;
      area_q <= tri_ok ? do_side.area : '0;
      rin_q  <= tri_ok ? do_side.rin : '0;
      rout_q <= !tri_ok ? '0 : (do_side.sat ? '1 : do_quo);
      sat_q  <= tri_ok && do_side.sat;
    end
  end

  assign valid_o           = out_vld_q;
  assign tri_class_o       = cls_q;
  assign perimeter_o       = per_q;
  assign area_o            = area_q;
  assign inner_radius_o    = rin_q;
  assign outer_radius_o    = rout_q;
  assign outer_saturated_o = sat_q;

endmodule

[rtl/tm_front.sv]
// Front pipeline: sums, triangle test, class, products and the scaled
// squared area. Depends on tm_pkg.
module tm_front import tm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SIDE_W-1:0] side_a_i,
  input  logic [SIDE_W-1:0] side_b_i,
  input  logic [SIDE_W-1:0] side_c_i,
  output logic              valid_o,
  output logic [SQ_W-1:0]   sq_o,
  output tm_side_t          side_o
);

  logic [DIFF_W-1:0] sum_bc, sum_ac, sum_ab;
  assign sum_bc = DIFF_W'(side_b_i) + DIFF_W'(side_c_i);
  assign sum_ac = DIFF_W'(side_a_i) + DIFF_W'(side_c_i);
  assign sum_ab = DIFF_W'(side_a_i) + DIFF_W'(side_b_i);

  // stage 1
  logic              v1_q;
  logic              notri1_q;
  logic [PER_W-1:0]  per1_q;
  logic [DIFF_W-1:0] x1_q, y1_q, z1_q;
  logic [SQR_W-1:0]  a2_q, b2_q, c2_q, ab1_q;
  logic [SIDE_W-1:0] c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      notri1_q <= (DIFF_W'(side_a_i) >= sum_bc) || (DIFF_W'(side_b_i) >= sum_ac) ||
                  (DIFF_W'(side_c_i) >= sum_ab);
      per1_q   <= PER_W'(sum_ab) + PER_W'(side_c_i);
      x1_q     <= sum_bc - DIFF_W'(side_a_i);
      y1_q     <= sum_ac - DIFF_W'(side_b_i);
      z1_q     <= sum_ab - DIFF_W'(side_c_i);
      a2_q     <= side_a_i * side_a_i;
      b2_q     <= side_b_i * side_b_i;
      c2_q     <= side_c_i * side_c_i;
      ab1_q    <= side_a_i * side_b_i;
      c1_q     <= side_c_i;
    end
  end

  // stage 2
  logic [SQR_W:0] s_bc, s_ac, s_ab;
  tm_class_e      cls_d;
  assign s_bc = (SQR_W+1)'(b2_q) + (SQR_W+1)'(c2_q);
  assign s_ac = (SQR_W+1)'(a2_q) + (SQR_W+1)'(c2_q);
  assign s_ab = (SQR_W+1)'(a2_q) + (SQR_W+1)'(b2_q);

  always_comb begin
    if (notri1_q) begin
      cls_d = CLS_NONE;
    end else if (((SQR_W+1)'(a2_q) == s_bc) || ((SQR_W+1)'(b2_q) == s_ac) ||
                 ((SQR_W+1)'(c2_q) == s_ab)) begin
      cls_d = CLS_RIGHT;
    end else if (((SQR_W+1)'(a2_q) > s_bc) || ((SQR_W+1)'(b2_q) > s_ac) ||
                 ((SQR_W+1)'(c2_q) > s_ab)) begin
      cls_d = CLS_OBTUSE;
    end else begin
      cls_d = CLS_ACUTE;
    end
  end

  logic              v2_q;
  tm_class_e         cls2_q;
  logic [PER_W-1:0]  per2_q;
  logic [XY_W-1:0]   xy2_q;
  logic [DIFF_W-1:0] z2_q;
  logic [ABC_W-1:0]  abc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls2_q <= cls_d;
      per2_q <= per1_q;
      xy2_q  <= x1_q * y1_q;
      z2_q   <= z1_q;
      abc2_q <= ab1_q * c1_q;
    end
  end

  // stage 3
  logic             v3_q;
  tm_class_e        cls3_q;
  logic [PER_W-1:0] per3_q;
  logic [XYZ_W-1:0] xyz3_q;
  logic [ABC_W-1:0] abc3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls3_q <= cls2_q;
      per3_q <= per2_q;
      xyz3_q <= xy2_q * z2_q;
      abc3_q <= abc2_q;
    end
  end

  // stage 4: split product of perimeter and xyz
  logic                      v4_q;
  tm_class_e                 cls4_q;
  logic [PER_W-1:0]          per4_q;
  logic [XYZ_W-1:0]          xyz4_q;
  logic [ABC_W-1:0]          abc4_q;
  logic [PER_W+XYZ_LO_W-1:0] plo4_q;
  logic [PER_W+XYZ_HI_W-1:0] phi4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls4_q <= cls3_q;
      per4_q <= per3_q;
      xyz4_q <= xyz3_q;
      abc4_q <= abc3_q;
      plo4_q <= per3_q * xyz3_q[XYZ_LO_W-1:0];
      phi4_q <= per3_q * xyz3_q[XYZ_W-1:XYZ_LO_W];
    end
  end

  // stage 5: recombine and scale
  logic [PROD_W-1:0] prod;
  assign prod = (PROD_W'(phi4_q) << XYZ_LO_W) + PROD_W'(plo4_q);

  logic             v5_q;
  logic [SQ_W-1:0]  sq5_q;
  tm_side_t         side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq5_q        <= SQ_W'(prod >> AREA_SH);
      side5_q.cls  <= cls4_q;
      side5_q.per  <= per4_q;
      side5_q.abc  <= abc4_q;
      side5_q.xyz  <= xyz4_q;
      side5_q.area <= '0;
      side5_q.rin  <= '0;
      side5_q.sat  <= 1'b0;
    end
  end

  assign valid_o = v5_q;
  assign sq_o    = sq5_q;
  assign side_o  = side5_q;

endmodule

[rtl/tm_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband
// tag that travels alongside. Depends on tm_pkg.
module tm_isqrt import tm_pkg::*; #(
  parameter int R_W   = AREA_W,
  parameter int TAG_W = SIDE_TAG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*R_W-1:0] v_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [R_W-1:0]   root_o,
  output logic [TAG_W-1:0] tag_o
);

  logic               vld_q  [R_W+1];
  logic [R_W+1:0]     rem_q  [R_W+1];
  logic [R_W-1:0]     root_q [R_W+1];
  logic [2*R_W-1:0]   vr_q   [R_W+1];
  logic [TAG_W-1:0]   tag_q  [R_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      vr_q[0]   <= v_i;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar s = 0; s < R_W; s++) begin : g_stage
    logic [R_W+1:0] t, trial, diff;
    logic           ge;
    assign t     = {rem_q[s][R_W-1:0], vr_q[s][2*R_W-1:2*R_W-2]};
    assign trial = {root_q[s], 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? diff : t;
        root_q[s+1] <= {root_q[s][R_W-2:0], ge};
        vr_q[s+1]   <= {vr_q[s][2*R_W-3:0], 2'b00};
        tag_q[s+1]  <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[R_W];
  assign root_o  = root_q[R_W];
  assign tag_o   = tag_q[R_W];

endmodule

[rtl/tm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for quotients
// known to fit in Q_W bits, with a sideband tag. Depends on tm_pkg.
module tm_div import tm_pkg::*; #(
  parameter int NUM_W = XYZ_W,
  parameter int DEN_W = PER_W + 2,
  parameter int Q_W   = RSQ_W,
  parameter int TAG_W = SIDE_TAG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_q [Q_W+1];
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   nq_q  [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [TAG_W-1:0] tag_q [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(num_i >> Q_W);
      nq_q[0]  <= num_i[Q_W-1:0];
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W:0] t, diff;
    logic           ge;
    assign t    = {rem_q[s], nq_q[s][Q_W-1]};
    assign ge   = t >= {1'b0, den_q[s]};
    assign diff = t - {1'b0, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        nq_q[s+1]  <= {nq_q[s][Q_W-2:0], ge};
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = nq_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

[dv/tb_triangle_metrics.sv]
// Testbench for triangle_metrics: queued driver, clocked monitor and an in-line
// predictor of class, perimeter, area and radii, compared as one whole record.
// Depends on tm_pkg and the triangle_metrics RTL.
module tb_triangle_metrics;
  import tm_pkg::*;

  typedef struct packed {
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
  } sides_t;

  typedef struct packed {
    tm_class_e         cls;
    logic [PER_W-1:0]  per;
    logic [AREA_W-1:0] area;
    logic [RIN_W-1:0]  rin;
    logic [ROUT_W-1:0] rout;
    logic              sat;
  } metrics_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              valid_i = 1'b0;
  logic              stall_o;
  logic [SIDE_W-1:0] side_a_i = '0;
  logic [SIDE_W-1:0] side_b_i = '0;
  logic [SIDE_W-1:0] side_c_i = '0;
  logic              valid_o;
  logic              stall_i = 1'b0;
  logic [1:0]        tri_class_o;
  logic [PER_W-1:0]  perimeter_o;
  logic [AREA_W-1:0] area_o;
  logic [RIN_W-1:0]  inner_radius_o;
  logic [ROUT_W-1:0] outer_radius_o;
  logic              outer_saturated_o;

  sides_t   pending_sides[$];
  metrics_t expected_metrics[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     send_pause = 1'b0;
  logic     recv_hold = 1'b0;
  int       mismatches = 0;

  triangle_metrics i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'h1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - r - bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  function automatic metrics_t predict_metrics(input sides_t s);
    metrics_t m;
    longint unsigned a, b, c, a2, b2, c2, per, x, y, z, xyz, hi, lo, sq, q;
    a = s.a;
    b = s.b;
    c = s.c;
    a2 = a * a;
    b2 = b * b;
    c2 = c * c;
    per = a + b + c;
    m = '0;
    m.per = per[PER_W-1:0];
    if (a >= b + c || b >= a + c || c >= a + b) begin
      m.cls = CLS_NONE;
      return m;
    end
    if (a2 == b2 + c2 || b2 == a2 + c2 || c2 == a2 + b2) m.cls = CLS_RIGHT;
    else if (a2 > b2 + c2 || b2 > a2 + c2 || c2 > a2 + b2) m.cls = CLS_OBTUSE;
    else m.cls = CLS_ACUTE;
    x = b + c - a;
    y = a + c - b;
    z = a + b - c;
    xyz = x * y * z;
    hi = xyz >> AREA_SH;
    lo = xyz & ((64'h1 << AREA_SH) - 1);
    sq = per * hi + ((per * lo) >> AREA_SH);
    q = int_sqrt(sq);
    m.area = q[AREA_W-1:0];
    q = int_sqrt(xyz / (4 * per));
    m.rin = q[RIN_W-1:0];
    if (m.area == 0) begin
      m.rout = '1;
      m.sat = 1'b1;
    end else begin
      q = (a * b * c) / ((64'(m.area)) * (64'd4 << FRAC_W));
      if (q > 64'hFFFFFF) begin
        m.rout = '1;
        m.sat = 1'b1;
      end else begin
        m.rout = q[ROUT_W-1:0];
      end
    end
    return m;
  endfunction

  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      expected_metrics.push_back(predict_metrics({side_a_i, side_b_i, side_c_i}));
    end
    if (!valid_i || !stall_o) begin
      if (rst_ni && !send_pause && pending_sides.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        valid_i <= 1'b1;
        {side_a_i, side_b_i, side_c_i} <= pending_sides.pop_front();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    metrics_t exp_m, got_m;
    if (valid_o && !stall_i) begin
      got_m = {tm_class_e'(tri_class_o), perimeter_o, area_o, inner_radius_o,
               outer_radius_o, outer_saturated_o};
      if (expected_metrics.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got_m);
      end else begin
        exp_m = expected_metrics.pop_front();
        if (got_m !== exp_m) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_m, got_m);
        end
      end
    end
    stall_i <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [SIDE_W-1:0] rand_side();
    int v;
    v = $urandom_range(65535, 1) >> $urandom_range(15);
    return (v == 0) ? 16'd1 : 16'(v);
  endfunction

  task automatic queue_random(input int n);
    sides_t s;
    int k, lo, hi, pick, t0, t1, t2;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        s = {16'($urandom), $urandom};
      end else if (pick < 15) begin
        s = {16'($urandom_range(65535)), 16'($urandom_range(65535)), 16'd0};
        if ($urandom_range(1)) s = {s.c, s.a, s.b};
      end else if (pick < 30) begin
        case ($urandom_range(2))
          0: begin t0 = 3; t1 = 4; t2 = 5; end
          1: begin t0 = 5; t1 = 12; t2 = 13; end
          default: begin t0 = 8; t1 = 15; t2 = 17; end
        endcase
        k = $urandom_range(65535 / t2, 1);
        s = {16'(t0 * k), 16'(t1 * k), 16'(t2 * k)};
        if ($urandom_range(1)) s = {s.b, s.c, s.a};
        if ($urandom_range(1)) s = {s.a, s.c, s.b};
      end else begin
        s.a = rand_side();
        s.b = ($urandom_range(3) == 0) ? s.a : rand_side();
        lo = ((s.a > s.b) ? s.a - s.b : s.b - s.a) + 1;
        hi = s.a + s.b - 1;
        if (hi > 65535) hi = 65535;
        s.c = (lo > hi) ? 16'(lo) : 16'($urandom_range(hi, lo));
        if ($urandom_range(1)) s = {s.c, s.a, s.b};
      end
      pending_sides.push_back(s);
    end
  endtask

  task automatic drain_queue();
    while (pending_sides.size() > 0 || valid_i) @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    @(negedge clk_i);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(n);
    drain_queue();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    pending_sides.push_back({16'd0, 16'd0, 16'd0});
    pending_sides.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_sides.push_back({16'hFFFF, 16'hFFFF, 16'd1});
    pending_sides.push_back({16'd768, 16'd1024, 16'd1280});
    pending_sides.push_back({16'd1280, 16'd768, 16'd1024});
    pending_sides.push_back({16'd256, 16'd256, 16'd512});
    pending_sides.push_back({16'd1, 16'd1, 16'd1});
    pending_sides.push_back({16'd1, 16'd2, 16'd2});
    pending_sides.push_back({16'd1000, 16'd1000, 16'd1999});
    pending_sides.push_back({16'd300, 16'd400, 16'd600});
    pending_sides.push_back({16'd400, 16'd500, 16'd600});
    pending_sides.push_back({16'hFFFF, 16'd1, 16'd1});
    pending_sides.push_back({16'd5, 16'hFFFF, 16'hFFFE});
    pending_sides.push_back({16'hAAAA, 16'h5555, 16'h8000});
    pending_sides.push_back({16'h7FFF, 16'h8000, 16'hFFFE});
    drain_queue();
    run_phase(0, 0, 300);
    run_phase(85, 0, 250);
    run_phase(0, 85, 250);
    run_phase(24, 24, 300);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b1;
    queue_random(250);
    repeat (400) @(negedge clk_i);
    recv_hold = 1'b0;
    drain_queue();
    @(negedge clk_i);
    send_pause = 1'b1;
    while (expected_metrics.size() > 0) @(negedge clk_i);
    send_pause = 1'b0;
    run_phase(10, 10, 150);
    while (expected_metrics.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && expected_metrics.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
